FILE: src/chj_pkg.sv
// ============================================================================
// chj_pkg
// Shared types and constants of the cuckoo hash join engine.
// ============================================================================
package chj_pkg;

    localparam int C_SLOTS        = 1024;
    localparam int C_POOL_ENTRIES = 4096;
    localparam int C_TAIL_COUNT   = 2;
    localparam int C_CHAIN_MAX    = 64;
    localparam int C_HASH_SHIFT   = 3;
    localparam int C_DATA_W       = 32;
    localparam int C_OP_W         = 2;
    localparam int C_STATUS_W     = 3;

    typedef enum logic [C_OP_W-1:0] {
        OP_BUILD = 2'd0,
        OP_PROBE = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    typedef enum logic [C_STATUS_W-1:0] {
        ST_MATCH      = 3'd0,
        ST_NO_MATCH   = 3'd1,
        ST_INSERTED   = 3'd2,
        ST_AGGREGATED = 3'd3,
        ST_OVERFLOW   = 3'd4,
        ST_POOL_FULL  = 3'd5,
        ST_CLEARED    = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        S_CLR,
        S_CLR_DONE,
        S_IDLE,
        S_H1,
        S_K1,
        S_H2,
        S_K2,
        S_MISS,
        S_NEW,
        S_CE,
        S_CS,
        S_CW,
        S_BWALK,
        S_PWALK
    } t_state;

endpackage

FILE: src/chj_if.sv
// ============================================================================
// chj_if
// Valid/ready channels for input items and result items.
// ============================================================================
interface chj_in_if import chj_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [C_OP_W-1:0]   opcode;
    logic [C_DATA_W-1:0] key;
    logic [C_DATA_W-1:0] tail_a;
    logic [C_DATA_W-1:0] tail_b;
    logic [C_DATA_W-1:0] multiplicity;

    modport source (output valid, opcode, key, tail_a, tail_b, multiplicity, input ready);
    modport sink   (input valid, opcode, key, tail_a, tail_b, multiplicity, output ready);
endinterface

interface chj_out_if import chj_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [C_DATA_W-1:0]   out_key;
    logic [C_DATA_W-1:0]   out_tail_a;
    logic [C_DATA_W-1:0]   out_tail_b;
    logic [C_DATA_W-1:0]   out_count;
    logic [C_STATUS_W-1:0] status;
    logic                  last;

    modport source (output valid, out_key, out_tail_a, out_tail_b, out_count, status, last,
                    input ready);
    modport sink   (input valid, out_key, out_tail_a, out_tail_b, out_count, status, last,
                    output ready);
endinterface

FILE: src/cuckoo_hash_join_engine.sv
// ============================================================================
// cuckoo_hash_join_engine
// Hash join over a two-table cuckoo hash with per-key chains in an entry pool.
// ============================================================================
// Usage:
//   i_in carries input items: opcode (build, probe, clear), key, two tails and
//   a multiplicity. o_out carries result items; the final one of an input
//   item has last set. Both are valid/ready; an item moves when both are high.
//   One item is worked on at a time. Steps per item:
//     build of a stored key: find the key, then walk the chain one entry
//       at a time (up to CHAIN_MAX entries).
//     build of a new key: look up both tables, then cuckoo tries
//       (read entry key, read slot, swap slot), at most SLOTS tries.
//     probe: find the key, then one result item per chain entry walked.
//     clear: a sweep over all 2*SLOTS slot memory entries, then the result item.
//   The slot and entry memories have a registered read port: every chain
//   step and cuckoo step waits on a dependent read.
//   Reset runs the same sweep over the slot memory; input ready stays low
//   until it is done. The result register holds an item while the receiver
//   stalls; a state that emits a result then holds until it is taken. The
//   engine accepts a new input item while the last result of the previous one waits.
// ============================================================================
module cuckoo_hash_join_engine
    import chj_pkg::*;
#(
    parameter int SLOTS        = C_SLOTS,
    parameter int POOL_ENTRIES = C_POOL_ENTRIES,
    parameter int TAIL_COUNT   = C_TAIL_COUNT,
    parameter int CHAIN_MAX    = C_CHAIN_MAX
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    chj_in_if.sink    i_in,
    chj_out_if.source o_out
);
    localparam int HASH_W = $clog2(SLOTS);          // bits of one table index
    localparam int SA_W   = $clog2(2 * SLOTS);      // slot memory address
    localparam int IDX_W  = $clog2(POOL_ENTRIES);   // entry memory address
    localparam int LINK_W = $clog2(POOL_ENTRIES + 1); // index+1, 0 = none
    localparam int N_W    = $clog2(CHAIN_MAX + 1);
    localparam int TRY_W  = $clog2(SLOTS);

    typedef struct packed {
        logic [C_DATA_W-1:0] key;
        logic [C_DATA_W-1:0] ta;
        logic [C_DATA_W-1:0] tb;
        logic [C_DATA_W-1:0] cnt;
        logic [LINK_W-1:0]   link;
    } t_entry;

    localparam int ENT_W = $bits(t_entry);

    // slot index: table one by low key bits, table two by mixed key bits
    function automatic logic [SA_W-1:0] f_slot(input logic [C_DATA_W-1:0] k,
                                               input logic second);
        logic [C_DATA_W-1:0] mix;
        mix = k ^ (k >> C_HASH_SHIFT);
        f_slot = second ? {1'b1, mix[HASH_W-1:0]} : {1'b0, k[HASH_W-1:0]};
    endfunction

    function automatic logic [IDX_W-1:0] f_idx(input logic [LINK_W-1:0] p);
        logic [LINK_W-1:0] d;
        d = p - LINK_W'(1);
        f_idx = d[IDX_W-1:0];
    endfunction

    // ---------------- registers ----------------
    t_state               r_state, n_state;
    logic [1:0]           r_op, n_op;
    logic [C_DATA_W-1:0]  r_key, n_key, r_ta, n_ta, r_tb, n_tb, r_m, n_m;
    logic [LINK_W-1:0]    r_h, n_h;         // head pointer of found slot
    logic [LINK_W-1:0]    r_p, n_p;         // walk pointer / cuckoo hand
    logic [N_W-1:0]       r_n, n_n;
    logic [SA_W-1:0]      r_ofs, n_ofs;     // slot of found key / cuckoo slot
    logic [SA_W-1:0]      r_clr, n_clr;
    logic                 r_reply, n_reply; // clear sweep answers an item
    logic                 r_first, n_first;
    logic [TRY_W-1:0]     r_tries, n_tries;
    logic [LINK_W-1:0]    r_fill, n_fill;

    logic                 r_ovalid;
    logic [C_DATA_W-1:0]  r_okey, r_ota, r_otb, r_ocnt;
    logic [C_STATUS_W-1:0] r_ost;
    logic                 r_olast;

    // ---------------- memory ports ----------------
    logic              s_we, s_re;
    logic [SA_W-1:0]   s_waddr, s_raddr;
    logic [LINK_W-1:0] s_wdata, s_rdata;
    logic              e_we, e_re;
    logic [IDX_W-1:0]  e_waddr, e_raddr;
    t_entry            e_wdata, e_rd;
    logic [ENT_W-1:0]  e_rdata;

    assign e_rd = t_entry'(e_rdata);

    chj_ram #(.WIDTH(LINK_W), .DEPTH(2 * SLOTS)) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(s_waddr),
        .i_wdata(s_wdata),
        .i_re   (s_re),
        .i_raddr(s_raddr),
        .o_rdata(s_rdata)
    );

    chj_ram #(.WIDTH(ENT_W), .DEPTH(POOL_ENTRIES)) u_entry_ram (
        .i_clk  (i_clk),
        .i_we   (e_we),
        .i_waddr(e_waddr),
        .i_wdata(ENT_W'(e_wdata)),
        .i_re   (e_re),
        .i_raddr(e_raddr),
        .o_rdata(e_rdata)
    );

    // ---------------- shared conditions ----------------
    logic              in_acc;
    logic              can_emit;  // result register free this cycle
    logic              pool_full;
    logic              key_hit;
    logic              tail_hit;
    logic [N_W-1:0]    n_next;
    logic              chain_cap;
    logic              try_end;
    logic [C_DATA_W-1:0] ta_in, tb_in;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign can_emit   = !r_ovalid || o_out.ready;
    assign pool_full  = (r_fill >= LINK_W'(POOL_ENTRIES));
    assign key_hit    = (e_rd.key == r_key);
    assign tail_hit   = (e_rd.ta == r_ta) && (e_rd.tb == r_tb);
    assign n_next     = r_n + N_W'(1);
    assign chain_cap  = (n_next >= N_W'(CHAIN_MAX));
    assign try_end    = (r_tries == TRY_W'(SLOTS - 1));
    assign ta_in      = (TAIL_COUNT >= 1) ? i_in.tail_a : '0;
    assign tb_in      = (TAIL_COUNT >= 2) ? i_in.tail_b : '0;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                if (r_clr == '1) n_state = r_reply ? S_CLR_DONE : S_IDLE;
            end
            S_CLR_DONE: begin
                if (can_emit) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in.opcode)
                        OP_BUILD, OP_PROBE: n_state = S_H1;
                        OP_CLEAR:           n_state = S_CLR;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            S_H1: n_state = (s_rdata != '0) ? S_K1 : S_H2;
            S_K1: begin
                if (key_hit) n_state = (r_op == OP_BUILD) ? S_BWALK : S_PWALK;
                else         n_state = S_H2;
            end
            S_H2: begin
                if (s_rdata != '0)          n_state = S_K2;
                else if (r_op == OP_BUILD)  n_state = S_NEW;
                else                        n_state = S_MISS;
            end
            S_K2: begin
                if (key_hit)               n_state = (r_op == OP_BUILD) ? S_BWALK : S_PWALK;
                else if (r_op == OP_BUILD) n_state = S_NEW;
                else                       n_state = S_MISS;
            end
            S_MISS: begin
                if (can_emit) n_state = S_IDLE;
            end
            S_NEW: begin
                if (pool_full) begin
                    if (can_emit) n_state = S_IDLE;
                end else begin
                    n_state = S_CE;
                end
            end
            S_CE: n_state = S_CS;
            S_CS: n_state = S_CW;
            S_CW: begin
                if (can_emit) n_state = ((s_rdata == '0) || try_end) ? S_IDLE : S_CE;
            end
            S_BWALK: begin
                if (can_emit) begin
                    if (tail_hit || e_rd.link == '0 || chain_cap) n_state = S_IDLE;
                end
            end
            S_PWALK: begin
                if (can_emit && (e_rd.link == '0 || chain_cap)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- datapath and memory control ----------------
    logic                  em;
    logic [C_DATA_W-1:0]   em_key, em_ta, em_tb, em_cnt;
    logic [C_STATUS_W-1:0] em_st;
    logic                  em_last;

    always_comb begin
        n_op = r_op; n_key = r_key; n_ta = r_ta; n_tb = r_tb; n_m = r_m;
        n_h = r_h; n_p = r_p; n_n = r_n; n_ofs = r_ofs; n_clr = r_clr;
        n_reply = r_reply; n_first = r_first; n_tries = r_tries; n_fill = r_fill;
        s_we = 1'b0; s_waddr = r_ofs; s_wdata = '0;
        s_re = 1'b0; s_raddr = f_slot(r_key, 1'b0);
        e_we = 1'b0; e_waddr = r_fill[IDX_W-1:0];
        e_wdata = '{key: r_key, ta: r_ta, tb: r_tb, cnt: r_m, link: '0};
        e_re = 1'b0; e_raddr = f_idx(r_p);
        em = 1'b0; em_key = r_key; em_ta = r_ta; em_tb = r_tb; em_cnt = '0;
        em_st = ST_INSERTED; em_last = 1'b1;

        unique case (r_state)
            S_CLR: begin
                s_we    = 1'b1;
                s_waddr = r_clr;
                n_clr   = r_clr + SA_W'(1);
                n_fill  = '0;
            end
            S_CLR_DONE: begin
                if (can_emit) begin
                    em = 1'b1; em_key = '0; em_ta = '0; em_tb = '0; em_st = ST_CLEARED;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_op  = i_in.opcode;
                    n_key = i_in.key;
                    n_ta  = ta_in;
                    n_tb  = tb_in;
                    n_m   = i_in.multiplicity;
                    n_clr = '0;
                    n_reply = 1'b1;
                    s_re    = 1'b1;
                    s_raddr = f_slot(i_in.key, 1'b0);
                end
            end
            S_H1: begin
                n_h = s_rdata;
                if (s_rdata != '0) begin
                    e_re = 1'b1; e_raddr = f_idx(s_rdata);
                end else begin
                    s_re = 1'b1; s_raddr = f_slot(r_key, 1'b1);
                end
            end
            S_K1: begin
                n_p = r_h; n_n = '0; n_ofs = f_slot(r_key, 1'b0);
                if (!key_hit) begin
                    s_re = 1'b1; s_raddr = f_slot(r_key, 1'b1);
                end
            end
            S_H2: begin
                n_h = s_rdata;
                if (s_rdata != '0) begin
                    e_re = 1'b1; e_raddr = f_idx(s_rdata);
                end
            end
            S_K2: begin
                n_p = r_h; n_n = '0; n_ofs = f_slot(r_key, 1'b1);
            end
            S_MISS: begin
                if (can_emit) begin
                    em = 1'b1; em_ta = '0; em_tb = '0; em_st = ST_NO_MATCH;
                end
            end
            S_NEW: begin
                if (pool_full) begin
                    if (can_emit) begin
                        em = 1'b1; em_st = ST_POOL_FULL;
                    end
                end else begin
                    e_we    = 1'b1;
                    n_p     = r_fill + LINK_W'(1);
                    n_fill  = r_fill + LINK_W'(1);
                    n_first = 1'b1;
                    n_tries = '0;
                end
            end
            S_CE: begin
                e_re = 1'b1; e_raddr = f_idx(r_p);
            end
            S_CS: begin
                n_ofs   = f_slot(e_rd.key, !r_first);
                s_re    = 1'b1;
                s_raddr = f_slot(e_rd.key, !r_first);
            end
            S_CW: begin
                if (can_emit) begin
                    s_we = 1'b1; s_waddr = r_ofs; s_wdata = r_p;
                    n_p  = s_rdata;
                    n_first = !r_first;
                    n_tries = r_tries + TRY_W'(1);
                    if (s_rdata == '0) begin
                        em = 1'b1; em_cnt = r_m; em_st = ST_INSERTED;
                    end else if (try_end) begin
                        em = 1'b1; em_st = ST_OVERFLOW;
                    end
                end
            end
            S_BWALK: begin
                if (can_emit) begin
                    if (tail_hit) begin
                        e_we    = 1'b1;
                        e_waddr = f_idx(r_p);
                        e_wdata = e_rd;
                        e_wdata.cnt = e_rd.cnt + r_m;
                        em = 1'b1; em_cnt = e_rd.cnt + r_m; em_st = ST_AGGREGATED;
                    end else if (e_rd.link != '0 && !chain_cap) begin
                        n_p = e_rd.link; n_n = n_next;
                        e_re = 1'b1; e_raddr = f_idx(e_rd.link);
                    end else if (chain_cap || pool_full) begin
                        em = 1'b1; em_st = ST_POOL_FULL;
                    end else begin
                        e_we = 1'b1;
                        e_wdata.link = r_h;
                        s_we = 1'b1; s_waddr = r_ofs; s_wdata = r_fill + LINK_W'(1);
                        n_fill = r_fill + LINK_W'(1);
                        em = 1'b1; em_cnt = r_m; em_st = ST_INSERTED;
                    end
                end
            end
            S_PWALK: begin
                if (can_emit) begin
                    em = 1'b1;
                    em_key = e_rd.key; em_ta = e_rd.ta; em_tb = e_rd.tb;
                    em_cnt = e_rd.cnt * r_m;
                    em_st = ST_MATCH;
                    em_last = (e_rd.link == '0) || chain_cap;
                    if (!em_last) begin
                        n_p = e_rd.link; n_n = n_next;
                        e_re = 1'b1; e_raddr = f_idx(e_rd.link);
                    end
                end
            end
            default: ;
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_reply  <= 1'b0;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
            r_n      <= '0;
            r_p      <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_reply <= n_reply;
            r_fill  <= n_fill;
            r_n     <= n_n;
            r_p     <= n_p;
            if (em)               r_ovalid <= 1'b1;
            else if (o_out.ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_key <= n_key; r_ta <= n_ta; r_tb <= n_tb; r_m <= n_m;
        r_h <= n_h; r_ofs <= n_ofs; r_first <= n_first; r_tries <= n_tries;
        if (em) begin
            r_okey  <= em_key;
            r_ota   <= em_ta;
            r_otb   <= em_tb;
            r_ocnt  <= em_cnt;
            r_ost   <= em_st;
            r_olast <= em_last;
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.out_key    = r_okey;
    assign o_out.out_tail_a = r_ota;
    assign o_out.out_tail_b = r_otb;
    assign o_out.out_count  = r_ocnt;
    assign o_out.status     = r_ost;
    assign o_out.last       = r_olast;

`ifndef NO_ASSERTIONS
    // pool allocation never passes the pool size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LINK_W'(POOL_ENTRIES))
        else $error("pool fill beyond pool size");

    // a chain walk always stands on a real entry
    a_walk_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BWALK || r_state == S_PWALK) |-> (r_p != '0))
        else $error("chain walk on null pointer");

    // walk depth stays under the chain limit
    a_chain_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BWALK || r_state == S_PWALK) |-> (r_n < N_W'(CHAIN_MAX)))
        else $error("chain walk past limit");

    // a pending result is never overwritten before it is taken
    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_out.ready) |=> (r_ovalid && $stable(r_ocnt) && $stable(r_ost)))
        else $error("pending result overwritten");
`endif

endmodule

FILE: src/chj_ram.sv
// ============================================================================
// chj_ram
// Simple dual-port RAM, one write port, one registered read port with enable.
// ============================================================================
module chj_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
